### hw/rtl/wma_pkg.sv
// Shared constants, types and state encodings of the warm-up moving average.
package wma_pkg;

  localparam int WINDOW    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
  localparam int STEP_W    = $clog2(SUM_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_WINDOW = CNT_W'(WINDOW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;

  // One queued job: window sum, its divisor and the full flag to report
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] divisor;
    logic             full;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

### hw/rtl/wma_in_if.sv
// Sample input channel: valid/ready handshake with the echo width payload.
interface wma_in_if;
  logic              valid;
  logic              ready;
  wma_pkg::sample_t  echo_width;

  modport source (output valid, output echo_width, input ready);
  modport sink   (input valid, input echo_width, output ready);
endinterface

### hw/rtl/wma_out_if.sv
// Result channel: valid/ready handshake with the mean and window-full flag.
interface wma_out_if;
  logic              valid;
  logic              ready;
  wma_pkg::sample_t  mean_value;
  logic              window_full;

  modport source (output valid, output mean_value, output window_full, input ready);
  modport sink   (input valid, input mean_value, input window_full, output ready);
endinterface

### hw/rtl/wma_front.sv
// Front end: accepts samples, maintains the sample ring and running sum, queues jobs.
module wma_front (
  input  logic                 clk,
  input  logic                 rst_n,
  wma_in_if.sink               in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output wma_pkg::job_t        q_job
);

  wma_pkg::front_state_t state_r, state_nxt;

  wma_pkg::sample_t              store_mem [wma_pkg::WINDOW];
  wma_pkg::sample_t              rd_data_r;
  wma_pkg::sample_t              x_r;
  logic [wma_pkg::CNT_W-1:0]     fill_count_r, fill_count_nxt;
  logic                          filled_r, filled_nxt;
  logic [wma_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [wma_pkg::PTR_W-1:0]     oldest_r, oldest_nxt;
  logic [wma_pkg::PTR_W-1:0]     slot;
  logic [wma_pkg::CNT_W-1:0]     count_inc;
  logic                          accept;
  logic                          update;

  assign slot      = filled_r ? oldest_r : fill_count_r[wma_pkg::PTR_W-1:0];
  assign count_inc = fill_count_r + wma_pkg::CNT_W'(1);
  assign accept    = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wma_pkg::F_IDLE:   if (accept) state_nxt = wma_pkg::F_UPDATE;
      wma_pkg::F_UPDATE: state_nxt = wma_pkg::F_IDLE;
      default:           state_nxt = wma_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    update      = 1'b0;
    case (state_r)
      wma_pkg::F_IDLE:   in_ch.ready = !q_full;
      wma_pkg::F_UPDATE: update = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
        update      = 1'b0;
      end
    endcase
  end

  // Drop the oldest sample only once the window has filled
  always_comb begin
    fill_count_nxt = fill_count_r;
    filled_nxt     = filled_r;
    oldest_nxt     = oldest_r;
    sum_nxt        = sum_r + wma_pkg::SUM_W'(x_r);
    if (filled_r) begin
      sum_nxt    = sum_r - wma_pkg::SUM_W'(rd_data_r) + wma_pkg::SUM_W'(x_r);
      oldest_nxt = (oldest_r == wma_pkg::PTR_LAST) ? '0 : oldest_r + wma_pkg::PTR_W'(1);
    end else begin
      fill_count_nxt = count_inc;
      if (count_inc >= wma_pkg::CNT_WINDOW) begin
        filled_nxt = 1'b1;
        oldest_nxt = '0;
      end
    end
  end

  assign q_push        = update;
  assign q_job.sum     = sum_nxt;
  assign q_job.divisor = filled_r ? wma_pkg::CNT_WINDOW : count_inc;
  assign q_job.full    = filled_nxt;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_ch.echo_width;
      rd_data_r <= store_mem[slot];
    end
    if (update) store_mem[slot] <= x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wma_pkg::F_IDLE;
      fill_count_r <= '0;
      filled_r     <= 1'b0;
      sum_r        <= '0;
      oldest_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (update) begin
        fill_count_r <= fill_count_nxt;
        filled_r     <= filled_nxt;
        sum_r        <= sum_nxt;
        oldest_r     <= oldest_nxt;
      end
    end
  end

endmodule

### hw/rtl/wma_queue.sv
// Two-entry job queue between the front end and the divider.
module wma_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wma_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output wma_pkg::job_t  pop_job,
  output logic           empty
);

  wma_pkg::job_t               entries [wma_pkg::QDEPTH];
  logic [wma_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [wma_pkg::QCNT_W-1:0]  count_r;
  logic                        do_push, do_pop;

  assign full    = (count_r == wma_pkg::QCNT_W'(wma_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + wma_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + wma_pkg::QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + wma_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - wma_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hw/rtl/wma_back.sv
// Back end: restoring serial divider and result output register.
module wma_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  wma_pkg::job_t  q_job,
  output logic           q_pop,
  wma_out_if.source      out_ch
);

  wma_pkg::back_state_t state_r, state_nxt;

  logic [wma_pkg::SUM_W-1:0]   quo_r;
  logic [wma_pkg::CNT_W-1:0]   rem_r;
  logic [wma_pkg::CNT_W-1:0]   div_r;
  logic                        full_r;
  logic [wma_pkg::STEP_W-1:0]  step_r;
  logic                        out_valid_r;
  wma_pkg::sample_t            mean_r;
  logic                        window_full_r;

  logic [wma_pkg::CNT_W:0]     trial;
  logic                        take;
  logic                        start, stepping, load_out, out_free;

  assign trial    = {rem_r, quo_r[wma_pkg::SUM_W-1]};
  assign take     = (trial >= {1'b0, div_r});
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wma_pkg::B_IDLE: if (!q_empty) state_nxt = wma_pkg::B_DIV;
      wma_pkg::B_DIV:  if (step_r == '0) state_nxt = wma_pkg::B_HOLD;
      wma_pkg::B_HOLD: if (out_free) state_nxt = wma_pkg::B_IDLE;
      default:         state_nxt = wma_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    stepping = 1'b0;
    load_out = 1'b0;
    case (state_r)
      wma_pkg::B_IDLE: start = !q_empty;
      wma_pkg::B_DIV:  stepping = 1'b1;
      wma_pkg::B_HOLD: load_out = out_free;
      default: begin
        start    = 1'b0;
        stepping = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign q_pop              = start;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean_value  = mean_r;
  assign out_ch.window_full = window_full_r;

  // Shift in one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= q_job.sum;
      rem_r  <= '0;
      div_r  <= q_job.divisor;
      full_r <= q_job.full;
      step_r <= wma_pkg::STEP_LAST;
    end else if (stepping) begin
      quo_r  <= {quo_r[wma_pkg::SUM_W-2:0], take};
      rem_r  <= take ? wma_pkg::CNT_W'(trial - {1'b0, div_r})
                     : trial[wma_pkg::CNT_W-1:0];
      step_r <= step_r - wma_pkg::STEP_W'(1);
    end
    if (load_out) begin
      mean_r        <= quo_r[wma_pkg::SAMPLE_W-1:0];
      window_full_r <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wma_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

endmodule

### hw/rtl/warmup_moving_average.sv
// Top level of the warm-up moving average: front end, job queue and divider.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid / ready     echo_width[15:0]
//   out_ch   out  valid / ready     mean_value[15:0], window_full
//
// In the front end the ring slot is read when a sample is accepted, then the sum
// is updated and the sample written back; no new sample is taken during the update.
// The back end divides with the one-bit-per-cycle restoring divider and loads the
// result into the output register. Reset is synchronous and active low and empties
// the window. The two-entry queue lets the front end keep accepting while the
// divider works or a result waits for out_ch.ready.
module warmup_moving_average (
  input  logic       clk,
  input  logic       rst_n,
  wma_in_if.sink     in_ch,
  wma_out_if.source  out_ch
);

  logic           q_push, q_full, q_pop, q_empty;
  wma_pkg::job_t  push_job, pop_job;

  wma_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  wma_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  wma_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
